>>> rtl/stereo_adaptive_sign_lms_predictor_assert.svh
// assertion macros for the stereo sign-lms predictor
// used by the sequencer and the top level
`ifndef STEREO_ADAPTIVE_SIGN_LMS_PREDICTOR_ASSERT_SVH
`define STEREO_ADAPTIVE_SIGN_LMS_PREDICTOR_ASSERT_SVH
// plain implication check under reset
`define SLP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication check under reset
`define SLP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/slp_pkg.sv
// shared types and constants for the stereo sign-lms predictor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package slp_pkg;
    localparam int OwnTaps   = 4;
    localparam int CrossTaps = 5;

    // reset values of the four starting own-history coefficients, entry 0 lowest
    localparam logic [3:0][15:0] InitAReset = {16'd98, 16'hFF93, 16'd317, 16'd360};

    typedef struct packed {
        logic signed [31:0] y_residual;
        logic signed [31:0] x_residual;
        logic               frame_start;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] y_out;
        logic signed [31:0] x_out;
    } out_item_t;

    typedef enum logic [2:0] {
        REG_STEREO_MODE = 3'd0,
        REG_INIT_A0     = 3'd1,
        REG_INIT_A1     = 3'd2,
        REG_INIT_A2     = 3'd3,
        REG_INIT_A3     = 3'd4
    } reg_index_t;

    // multiplier request
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [3:0] n);
        asr = 32'($signed(v) >>> n);
    endfunction

    // sign as two-bit code: 01 positive, 11 negative, 00 zero
    function automatic logic [1:0] sgn(input logic [31:0] v);
        if (v == 32'd0)
            sgn = 2'b00;
        else if (v[31])
            sgn = 2'b11;
        else
            sgn = 2'b01;
    endfunction

    function automatic logic [31:0] sign_prod(input logic [1:0] a, input logic [1:0] b);
        if (a == 2'b00 || b == 2'b00)
            sign_prod = 32'd0;
        else if (a[1] ^ b[1])
            sign_prod = 32'hFFFF_FFFF;
        else
            sign_prod = 32'd1;
    endfunction
endpackage
`default_nettype wire

>>> rtl/slp_mul.sv
// registered 32x32 wrapping multiplier shared by all products
// depends on slp_pkg
`timescale 1ns / 1ps
`default_nettype none
module slp_mul (
    input  wire logic             clk,
    input  wire slp_pkg::mul_req_t req,
    output logic [31:0]           product
);
    logic [31:0] product_reg;
    always_ff @(posedge clk)
    begin
        product_reg <= req.a * req.b;
    end
    assign product = product_reg;
endmodule
`default_nettype wire

>>> rtl/slp_core.sv
// per-item sequencer and predictor state for both channels
// depends on slp_pkg, slp_mul and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_adaptive_sign_lms_predictor_assert.svh"
module slp_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire slp_pkg::in_item_t item,
    input  wire logic              stereo_mode,
    input  wire logic [15:0]       init_a [4],
    input  wire logic              hold,
    output logic                   busy,
    output logic                   done,
    output slp_pkg::out_item_t     result
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PREP  = 6'b000010,
        S_MUL   = 6'b000100,
        S_ACC   = 6'b001000,
        S_FIN   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] step_reg;   // product index 0..10 (0 and 10 are the 31/32 terms), 11 after the last
    logic       ch_reg;

    logic [31:0] last_value_reg [2];
    logic [31:0] h_reg  [2][4];
    logic [31:0] g_reg  [2][5];
    logic [1:0]  hs_reg [2][4];
    logic [1:0]  gs_reg [2][5];
    logic [31:0] hc_reg [2][4];
    logic [31:0] gc_reg [2][5];
    logic [31:0] cip_reg [2];
    logic [31:0] op_reg [2];
    logic [31:0] xop_reg;
    logic [31:0] pa_reg, pb_reg, b_reg, yo_reg;
    logic signed [31:0] y_res_reg, x_res_reg;
    logic        fs_reg;

    slp_pkg::mul_req_t req;
    logic [31:0] product;

    slp_mul u_mul (.clk(clk), .req(req), .product(product));

    logic [31:0] a_cur;
    assign a_cur = ch_reg ? x_res_reg : y_res_reg;

    // operand select: step 0 ci*31, 1..4 own taps, 5..9 cross taps, 10 out*31
    always_comb
    begin
        req.a = 32'd0;
        req.b = 32'd0;
        if (step_reg == 4'd0)
        begin
            req.a = cip_reg[ch_reg];
            req.b = 32'd31;
        end
        else if (step_reg <= 4'd4)
        begin
            req.a = h_reg[ch_reg][2'(step_reg - 4'd1)];
            req.b = hc_reg[ch_reg][2'(step_reg - 4'd1)];
        end
        else if (step_reg <= 4'd9)
        begin
            req.a = g_reg[ch_reg][3'(step_reg - 4'd5)];
            req.b = gc_reg[ch_reg][3'(step_reg - 4'd5)];
        end
        else
        begin
            req.a = op_reg[ch_reg];
            req.b = 32'd31;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_PREP;
            S_PREP: state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = (step_reg == 4'd10) ? S_FIN : S_MUL;
            S_FIN:  state_next = (!ch_reg && stereo_mode) ? S_PREP : S_DONE;
            // wait here while the output register still holds the previous item
            S_DONE: state_next = hold ? S_DONE : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic [31:0] lv_new, out_new, g0_new;
    assign lv_new = a_cur + slp_pkg::asr(pa_reg + slp_pkg::asr(pb_reg, 4'd1), 4'd10);
    assign out_new = lv_new + slp_pkg::asr(product, 4'd5);
    assign g0_new = b_reg - slp_pkg::asr(product, 4'd5);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 4'd0;
            ch_reg    <= 1'b0;
            xop_reg   <= 32'd0;
            fs_reg    <= 1'b0;
            for (int c = 0; c < 2; c++)
            begin
                last_value_reg[c] <= 32'd0;
                cip_reg[c] <= 32'd0;
                op_reg[c]  <= 32'd0;
                for (int i = 0; i < 4; i++)
                begin
                    h_reg[c][i]  <= 32'd0;
                    hs_reg[c][i] <= 2'b00;
                    hc_reg[c][i] <= 32'(signed'(slp_pkg::InitAReset[i]));
                end
                for (int i = 0; i < 5; i++)
                begin
                    g_reg[c][i]  <= 32'd0;
                    gs_reg[c][i] <= 2'b00;
                    gc_reg[c][i] <= 32'd0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        y_res_reg <= item.y_residual;
                        x_res_reg <= item.x_residual;
                        fs_reg    <= item.frame_start;
                        ch_reg    <= 1'b0;
                        b_reg     <= stereo_mode ? xop_reg : 32'd0;
                    end
                end
                S_PREP:
                begin
                    if (fs_reg && !ch_reg)
                    begin
                        xop_reg <= 32'd0;
                        for (int c = 0; c < 2; c++)
                        begin
                            last_value_reg[c] <= 32'd0;
                            cip_reg[c] <= 32'd0;
                            op_reg[c]  <= 32'd0;
                            for (int i = 0; i < 4; i++)
                            begin
                                h_reg[c][i]  <= 32'd0;
                                hs_reg[c][i] <= 2'b00;
                                hc_reg[c][i] <= 32'(signed'(init_a[i]));
                            end
                            for (int i = 0; i < 5; i++)
                            begin
                                g_reg[c][i]  <= 32'd0;
                                gs_reg[c][i] <= 2'b00;
                                gc_reg[c][i] <= 32'd0;
                            end
                        end
                        b_reg <= 32'd0;
                    end
                    else
                    begin
                        h_reg[ch_reg][0] <= last_value_reg[ch_reg];
                        h_reg[ch_reg][1] <= last_value_reg[ch_reg] - h_reg[ch_reg][1];
                    end
                    step_reg <= 4'd0;
                    pa_reg   <= 32'd0;
                    pb_reg   <= 32'd0;
                    fs_reg   <= 1'b0;
                end
                S_MUL: ;
                S_ACC:
                begin
                    if (step_reg == 4'd0)
                    begin
                        g_reg[ch_reg][0] <= g0_new;
                        g_reg[ch_reg][1] <= g0_new - g_reg[ch_reg][1];
                        cip_reg[ch_reg]  <= b_reg;
                    end
                    else if (step_reg <= 4'd4)
                        pa_reg <= pa_reg + product;
                    else if (step_reg <= 4'd9)
                        pb_reg <= pb_reg + product;
                    else
                    begin
                        last_value_reg[ch_reg] <= lv_new;
                        op_reg[ch_reg] <= out_new;
                        if (ch_reg)
                            xop_reg <= out_new;
                        else
                        begin
                            yo_reg <= out_new;
                            b_reg  <= out_new;
                        end
                    end
                    step_reg <= step_reg + 4'd1;
                end
                S_FIN:
                begin
                    for (int i = 0; i < 4; i++)
                        hc_reg[ch_reg][i] <= hc_reg[ch_reg][i] + slp_pkg::sign_prod(
                            (i == 0) ? slp_pkg::sgn(h_reg[ch_reg][0]) :
                            (i == 1) ? slp_pkg::sgn(h_reg[ch_reg][1]) : hs_reg[ch_reg][i],
                            slp_pkg::sgn(a_cur));
                    for (int i = 0; i < 5; i++)
                        gc_reg[ch_reg][i] <= gc_reg[ch_reg][i] + slp_pkg::sign_prod(
                            (i == 0) ? slp_pkg::sgn(g_reg[ch_reg][0]) :
                            (i == 1) ? slp_pkg::sgn(g_reg[ch_reg][1]) : gs_reg[ch_reg][i],
                            slp_pkg::sgn(a_cur));
                    for (int i = 1; i < 4; i++)
                        h_reg[ch_reg][i] <= h_reg[ch_reg][i-1];
                    hs_reg[ch_reg][1] <= slp_pkg::sgn(h_reg[ch_reg][0]);
                    hs_reg[ch_reg][2] <= slp_pkg::sgn(h_reg[ch_reg][1]);
                    hs_reg[ch_reg][3] <= hs_reg[ch_reg][2];
                    for (int i = 1; i < 5; i++)
                        g_reg[ch_reg][i] <= g_reg[ch_reg][i-1];
                    gs_reg[ch_reg][1] <= slp_pkg::sgn(g_reg[ch_reg][0]);
                    gs_reg[ch_reg][2] <= slp_pkg::sgn(g_reg[ch_reg][1]);
                    gs_reg[ch_reg][3] <= gs_reg[ch_reg][2];
                    gs_reg[ch_reg][4] <= gs_reg[ch_reg][3];
                    // channel x only runs in stereo, so x_out stays zero in mono
                    if (stereo_mode)
                        ch_reg <= 1'b1;
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE) && !hold;
    assign result.y_out = yo_reg;
    assign result.x_out = ch_reg ? xop_reg : 32'd0;

    `SLP_ASSERT_IMP(a_start_idle, start, state_reg == S_IDLE)
    `SLP_ASSERT_NXT(a_done_idle, state_reg == S_DONE && !hold, state_reg == S_IDLE)
    `SLP_ASSERT_IMP(a_step_range, state_reg == S_ACC, step_reg <= 4'd10)
endmodule
`default_nettype wire

>>> rtl/stereo_adaptive_sign_lms_predictor.sv
// stereo sign-sign lms prediction stage of a lossless audio decoder.
// each channel takes a prep state, eleven products (history 31/32 term,
// four own taps, five cross taps, output 31/32 term) through one shared
// registered 32x32 multiplier, each in a multiply and an accumulate state,
// then a coefficient update state; a done state then hands the result over.
// input stall is high while an item is in work, so the next item is taken
// only after the done state; a stalled result waits in the output register
// while the next item runs, and the core holds its done state until it is free.
// depends on slp_pkg, slp_core, slp_mul and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_adaptive_sign_lms_predictor_assert.svh"
module stereo_adaptive_sign_lms_predictor (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire slp_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output slp_pkg::out_item_t     out_data,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);
    logic        stereo_mode_reg;
    logic [15:0] init_a_reg [4];
    logic        busy, done, start, hold;
    slp_pkg::out_item_t result;
    logic        out_valid_reg;
    slp_pkg::out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_mode_reg <= 1'b1;
            init_a_reg[0] <= slp_pkg::InitAReset[0];
            init_a_reg[1] <= slp_pkg::InitAReset[1];
            init_a_reg[2] <= slp_pkg::InitAReset[2];
            init_a_reg[3] <= slp_pkg::InitAReset[3];
        end
        else if (cfg_we)
        begin
            unique case (slp_pkg::reg_index_t'(cfg_index))
                slp_pkg::REG_STEREO_MODE: stereo_mode_reg <= cfg_data[0];
                slp_pkg::REG_INIT_A0:     init_a_reg[0] <= cfg_data;
                slp_pkg::REG_INIT_A1:     init_a_reg[1] <= cfg_data;
                slp_pkg::REG_INIT_A2:     init_a_reg[2] <= cfg_data;
                slp_pkg::REG_INIT_A3:     init_a_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_stall = busy;
    assign start = in_valid && !in_stall;
    // output register stays occupied through this edge
    assign hold = out_valid_reg && out_stall;

    slp_core u_core (
        .clk(clk), .rst_n(rst_n), .start(start), .item(in_data),
        .stereo_mode(stereo_mode_reg), .init_a(init_a_reg), .hold(hold),
        .busy(busy), .done(done), .result(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SLP_ASSERT_IMP(a_no_overlap, done, !out_valid_reg || !out_stall)
    `SLP_ASSERT_NXT(a_done_shows, done, out_valid_reg)
    `SLP_ASSERT_IMP(a_busy_stalls, busy, in_stall)
endmodule
`default_nettype wire

>>> test/tb_stereo_adaptive_sign_lms_predictor.sv
// self-checking testbench for the stereo sign-lms predictor
// predicts every result pair in a behavioral model and compares in order
// depends on slp_pkg and the predictor top level
`timescale 1ns / 1ps
module tb_stereo_adaptive_sign_lms_predictor;
    localparam int CycleLimit = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    slp_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    slp_pkg::out_item_t out_data;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    int errors;
    int cycles;
    slp_pkg::out_item_t expected_q[$];

    // predictor state
    logic        mdl_stereo;
    logic [15:0] mdl_init[4];
    logic [31:0] mdl_last[2];
    logic [31:0] mdl_own_h[2][4];
    logic [31:0] mdl_cross_h[2][5];
    logic [1:0]  mdl_own_s[2][4];
    logic [1:0]  mdl_cross_s[2][5];
    logic [31:0] mdl_own_c[2][4];
    logic [31:0] mdl_cross_c[2][5];
    logic [31:0] mdl_cross_prev[2];
    logic [31:0] mdl_out_prev[2];
    logic [31:0] mdl_x_prev;

    stereo_adaptive_sign_lms_predictor u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] shr(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [1:0] sign_code(input logic [31:0] v);
        if (v == 0)
            return 2'b00;
        return v[31] ? 2'b11 : 2'b01;
    endfunction

    function automatic logic [31:0] step_of(input logic [1:0] a, input logic [1:0] b);
        if (a == 2'b00 || b == 2'b00)
            return 32'd0;
        return (a[1] ^ b[1]) ? 32'hFFFF_FFFF : 32'd1;
    endfunction

    task automatic clear_filters();
        for (int c = 0; c < 2; c++)
        begin
            mdl_last[c] = 0;
            mdl_cross_prev[c] = 0;
            mdl_out_prev[c] = 0;
            for (int i = 0; i < 4; i++)
            begin
                mdl_own_h[c][i] = 0;
                mdl_own_s[c][i] = 0;
                mdl_own_c[c][i] = {{16{mdl_init[i][15]}}, mdl_init[i]};
            end
            for (int i = 0; i < 5; i++)
            begin
                mdl_cross_h[c][i] = 0;
                mdl_cross_s[c][i] = 0;
                mdl_cross_c[c][i] = 0;
            end
        end
        mdl_x_prev = 0;
    endtask

    task automatic filter_channel(input int c, input logic [31:0] a, input logic [31:0] b,
                                  output logic [31:0] res);
        logic [31:0] pa;
        logic [31:0] pb;
        logic [1:0] rs;
        pa = 0;
        pb = 0;
        mdl_own_h[c][0] = mdl_last[c];
        mdl_own_h[c][1] = mdl_own_h[c][0] - mdl_own_h[c][1];
        for (int i = 0; i < 4; i++)
            pa += mdl_own_h[c][i] * mdl_own_c[c][i];
        mdl_cross_h[c][0] = b - shr(mdl_cross_prev[c] * 32'd31, 5);
        mdl_cross_prev[c] = b;
        mdl_cross_h[c][1] = mdl_cross_h[c][0] - mdl_cross_h[c][1];
        for (int i = 0; i < 5; i++)
            pb += mdl_cross_h[c][i] * mdl_cross_c[c][i];
        mdl_last[c] = a + shr(pa + shr(pb, 1), 10);
        res = mdl_last[c] + shr(mdl_out_prev[c] * 32'd31, 5);
        mdl_out_prev[c] = res;
        rs = sign_code(a);
        mdl_own_s[c][0] = sign_code(mdl_own_h[c][0]);
        mdl_own_s[c][1] = sign_code(mdl_own_h[c][1]);
        mdl_cross_s[c][0] = sign_code(mdl_cross_h[c][0]);
        mdl_cross_s[c][1] = sign_code(mdl_cross_h[c][1]);
        for (int i = 0; i < 4; i++)
            mdl_own_c[c][i] += step_of(mdl_own_s[c][i], rs);
        for (int i = 0; i < 5; i++)
            mdl_cross_c[c][i] += step_of(mdl_cross_s[c][i], rs);
        for (int i = 3; i > 0; i--)
        begin
            mdl_own_h[c][i] = mdl_own_h[c][i-1];
            mdl_own_s[c][i] = mdl_own_s[c][i-1];
        end
        for (int i = 4; i > 0; i--)
        begin
            mdl_cross_h[c][i] = mdl_cross_h[c][i-1];
            mdl_cross_s[c][i] = mdl_cross_s[c][i-1];
        end
    endtask

    task automatic predict_pair(input slp_pkg::in_item_t it);
        slp_pkg::out_item_t r;
        logic [31:0] yo;
        logic [31:0] xo;
        if (it.frame_start)
            clear_filters();
        xo = 0;
        if (mdl_stereo)
        begin
            filter_channel(0, it.y_residual, mdl_x_prev, yo);
            filter_channel(1, it.x_residual, yo, xo);
            mdl_x_prev = xo;
        end
        else
            filter_channel(0, it.y_residual, 32'd0, yo);
        r.y_out = yo;
        r.x_out = xo;
        expected_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // valid stays high into the next item when no gap is drawn
    task automatic send_pair(input logic [31:0] y, input logic [31:0] x, input logic fs);
        slp_pkg::in_item_t it;
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.y_residual = y;
        it.x_residual = x;
        it.frame_start = fs;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pair(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input slp_pkg::reg_index_t idx, input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == slp_pkg::REG_STEREO_MODE)
            mdl_stereo = v[0];
        else
            mdl_init[int'(idx) - 1] = v;
    endtask

    function automatic logic [31:0] rand_residual();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 64)) - 32);
            2: return 32'($signed($urandom_range(0, 65535)) - 32768);
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    task automatic test_directed_extremes();
        send_pair(32'd0, 32'd0, 1'b1);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'd1, 1'b0);
        send_pair(32'd1, 32'hFFFF_FFFF, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_pair(32'd1000, 32'hFFFF_FC18, 1'b1);
        send_pair(32'd0, 32'd0, 1'b0);
        // pause until all results are back
        wait_drained();
    endtask

    task automatic test_coeff_extremes();
        write_reg(slp_pkg::REG_INIT_A0, 16'h7FFF);
        write_reg(slp_pkg::REG_INIT_A1, 16'h8000);
        write_reg(slp_pkg::REG_INIT_A2, 16'hFFFF);
        write_reg(slp_pkg::REG_INIT_A3, 16'h0000);
        // new coefficients apply only from the next frame start
        send_pair(32'd500, 32'd700, 1'b0);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        for (int i = 0; i < 6; i++)
            send_pair(rand_residual(), rand_residual(), 1'b0);
        wait_drained();
    endtask

    task automatic test_mode_changes();
        write_reg(slp_pkg::REG_STEREO_MODE, 16'd0);
        send_pair(32'd300, 32'd999, 1'b1);
        send_pair(32'hFFFF_FF00, 32'h1234_5678, 1'b0);
        wait_drained();
        // switch mid frame, channels continue from their state
        write_reg(slp_pkg::REG_STEREO_MODE, 16'd1);
        send_pair(32'd77, 32'hFFFF_FFB3, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(slp_pkg::REG_STEREO_MODE, 16'(ph % 3 != 2));
            write_reg(slp_pkg::REG_INIT_A0, 16'($urandom));
            write_reg(slp_pkg::REG_INIT_A1, 16'($urandom));
            write_reg(slp_pkg::REG_INIT_A2, 16'($urandom));
            write_reg(slp_pkg::REG_INIT_A3, 16'($urandom));
            if (ph == 5)
            begin
                write_reg(slp_pkg::REG_INIT_A0, 16'd360);
                write_reg(slp_pkg::REG_INIT_A1, 16'd317);
                write_reg(slp_pkg::REG_INIT_A2, 16'hFF93);
                write_reg(slp_pkg::REG_INIT_A3, 16'd98);
            end
            for (int i = 0; i < 72; i++)
                send_pair(rand_residual(), rand_residual(),
                          i == 0 || $urandom_range(0, 40) == 0);
            wait_drained();
        end
    endtask

    // output stall draw, with stall-free stretches
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int n;
            n = $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0)
                n = 0;
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected y_out", out_data.y_out, 32'd0);
            else
            begin
                slp_pkg::out_item_t want;
                want = expected_q.pop_front();
                if (out_data.y_out !== want.y_out)
                    report_mismatch("y_out", out_data.y_out, want.y_out);
                if (out_data.x_out !== want.x_out)
                    report_mismatch("x_out", out_data.x_out, want.x_out);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("stereo_adaptive_sign_lms_predictor regression: fail");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = slp_pkg::REG_STEREO_MODE;
        cfg_data = '0;
        mdl_stereo = 1'b1;
        mdl_init[0] = 16'd360;
        mdl_init[1] = 16'd317;
        mdl_init[2] = 16'hFF93;
        mdl_init[3] = 16'd98;
        clear_filters();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_coeff_extremes();
        test_mode_changes();
        test_random_phases();
        wait_drained();
        if (errors == 0 && expected_q.size() == 0)
            $display("stereo_adaptive_sign_lms_predictor regression: pass");
        else
            $display("stereo_adaptive_sign_lms_predictor regression: fail");
        $finish;
    end
endmodule
